>>> rtl/core/pfx_pkg.sv
// shared types and codes of the postfix expression stack engine
package pfx_pkg;

   localparam logic [2:0] CMD_PUSH_NUM = 3'd0;
   localparam logic [2:0] CMD_PUSH_VAR = 3'd1;
   localparam logic [2:0] CMD_OPERATE  = 3'd2;
   localparam logic [2:0] CMD_POP      = 3'd3;
   localparam logic [2:0] CMD_ASSIGN   = 3'd4;

   localparam logic [4:0] OP_ADD  = 5'd0;
   localparam logic [4:0] OP_SUB  = 5'd1;
   localparam logic [4:0] OP_MUL  = 5'd2;
   localparam logic [4:0] OP_DIV  = 5'd3;
   localparam logic [4:0] OP_MOD  = 5'd4;
   localparam logic [4:0] OP_NEG  = 5'd5;
   localparam logic [4:0] OP_NOT  = 5'd6;
   localparam logic [4:0] OP_LT   = 5'd7;
   localparam logic [4:0] OP_GT   = 5'd8;
   localparam logic [4:0] OP_EQ   = 5'd9;
   localparam logic [4:0] OP_LE   = 5'd10;
   localparam logic [4:0] OP_GE   = 5'd11;
   localparam logic [4:0] OP_NE   = 5'd12;
   localparam logic [4:0] OP_AND  = 5'd13;
   localparam logic [4:0] OP_OR   = 5'd14;
   localparam logic [4:0] OP_ABS  = 5'd15;
   localparam logic [4:0] OP_ZERO = 5'd16;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_UNDER = 3'd1;
   localparam logic [2:0] ST_OVER  = 3'd2;
   localparam logic [2:0] ST_DIVZ  = 3'd3;
   localparam logic [2:0] ST_FULL  = 3'd4;

   // one classified job handed from front to back
   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [15:0] number;
      logic [15:0]        key;
      logic [4:0]         op;
   } job_type;

endpackage

>>> rtl/core/pfx_req_if.sv
// request channel interface
interface pfx_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         cmd;
   logic signed [15:0] number;
   logic [7:0]         name_first;
   logic [7:0]         name_second;
   logic [4:0]         op;

   modport source (output valid, cmd, number, name_first, name_second, op, input ready);
   modport sink (input valid, cmd, number, name_first, name_second, op, output ready);
endinterface

>>> rtl/core/pfx_rsp_if.sv
// response channel interface
interface pfx_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] value;
   logic [2:0]         status;

   modport source (output valid, value, status, input ready);
   modport sink (input valid, value, status, output ready);
endinterface

>>> rtl/core/pfx_front.sv
// front end: accepts requests, forms the variable key, queues jobs
module pfx_front (
   input  logic           clock,
   input  logic           reset,
   pfx_req_if.sink        req_chan,
   output pfx_pkg::job_type job,
   output logic           job_valid,
   input  logic           job_pop
);

   pfx_pkg::job_type q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push;
   logic       pop;
   logic [15:0] key;

   // key = first + second * 127
   assign key = 16'({8'd0, req_chan.name_first}) + 16'({1'b0, req_chan.name_second, 7'd0})
              - 16'({8'd0, req_chan.name_second});

   assign req_chan.ready = (cnt_ff != 2'd2);
   assign push      = req_chan.valid && req_chan.ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop       = job_pop && job_valid;
   assign job       = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{cmd: req_chan.cmd, number: req_chan.number, key: key,
                              op: req_chan.op};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop) cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
      end
   end

endmodule

>>> rtl/core/pfx_back.sv
// back end: stack and variable table sequencer with iterative divide
module pfx_back #(
   parameter int STACK_DEPTH = 32,
   parameter int VAR_SLOTS   = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  pfx_pkg::job_type job,
   input  logic             job_valid,
   output logic             job_pop,
   pfx_rsp_if.source        rsp_chan
);

   localparam int LW  = $clog2(STACK_DEPTH + 1);
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int CW  = $clog2(VAR_SLOTS + 1);
   localparam int VIW = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_READ = 4'd1;
   localparam logic [3:0] S_EXEC = 4'd2;
   localparam logic [3:0] S_SRD  = 4'd3;
   localparam logic [3:0] S_SCMP = 4'd4;
   localparam logic [3:0] S_DIV  = 4'd5;
   localparam logic [3:0] S_DIVF = 4'd6;
   localparam logic [3:0] S_OUT  = 4'd7;

   logic [15:0] stk_mem [STACK_DEPTH];
   logic [15:0] key_mem [VAR_SLOTS];
   logic [15:0] val_mem [VAR_SLOTS];

   logic [3:0]   state_ff, state_in;
   pfx_pkg::job_type job_ff;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VIW-1:0] sidx_ff, sidx_in;
   logic [15:0]  top_ff, nxt_ff, kr_ff, vr_ff;
   logic [15:0]  dq_ff, dq_in, dd_ff, dd_in;
   logic [16:0]  dr_ff, dr_in;
   logic [3:0]   dcnt_ff, dcnt_in;
   logic [15:0]  resv_ff, resv_in;
   logic [2:0]   ress_ff, ress_in;
   logic         ov_ff, ov_in;
   logic [15:0]  ovv_ff, ovv_in;
   logic [2:0]   ovs_ff, ovs_in;

   logic          stk_we;
   logic [SAW-1:0] stk_wa;
   logic [15:0]   stk_wd;
   logic          var_we, key_we;
   logic [VIW-1:0] var_wa;
   logic [15:0]   val_wd;

   logic [LW-1:0] lvl_m1, lvl_m2;
   logic signed [15:0] sa, sb;
   logic [15:0]  r_bin, r_un, ua, ub, qv, rv;
   logic [31:0]  prod;
   logic [16:0]  dt;
   logic         full_stk, hit, last;

   assign lvl_m1 = lvl_ff - LW'(1);
   assign lvl_m2 = lvl_ff - LW'(2);
   assign sa = $signed(nxt_ff);
   assign sb = $signed(top_ff);
   assign prod = 32'($signed(sa) * $signed(sb));
   assign full_stk = (lvl_ff >= LW'(STACK_DEPTH));
   assign ua = sa[15] ? 16'(-sa) : nxt_ff;
   assign ub = sb[15] ? 16'(-sb) : top_ff;
   assign dt = {dr_ff[15:0], dq_ff[15]};
   assign hit = (kr_ff == job_ff.key);
   assign last = (CW'(sidx_ff) + CW'(1) == cnt_ff);
   assign qv = (sa[15] ^ sb[15]) ? 16'(-dq_ff) : dq_ff;
   assign rv = sa[15] ? 16'(-dr_ff[15:0]) : dr_ff[15:0];

   always_comb begin
      case (job_ff.op)
         pfx_pkg::OP_ADD: r_bin = 16'(sa + sb);
         pfx_pkg::OP_SUB: r_bin = 16'(sa - sb);
         pfx_pkg::OP_MUL: r_bin = prod[15:0];
         pfx_pkg::OP_LT:  r_bin = {15'd0, sa < sb};
         pfx_pkg::OP_GT:  r_bin = {15'd0, sa > sb};
         pfx_pkg::OP_EQ:  r_bin = {15'd0, sa == sb};
         pfx_pkg::OP_LE:  r_bin = {15'd0, sa <= sb};
         pfx_pkg::OP_GE:  r_bin = {15'd0, sa >= sb};
         pfx_pkg::OP_NE:  r_bin = {15'd0, sa != sb};
         pfx_pkg::OP_AND: r_bin = {15'd0, (sa != 0) && (sb != 0)};
         default:         r_bin = {15'd0, (sa != 0) || (sb != 0)};
      endcase
      case (job_ff.op)
         pfx_pkg::OP_NEG: r_un = 16'(-sb);
         pfx_pkg::OP_NOT: r_un = {15'd0, sb == 0};
         pfx_pkg::OP_ABS: r_un = ub;
         default:         r_un = 16'd0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      lvl_in = lvl_ff;
      cnt_in = cnt_ff;
      sidx_in = sidx_ff;
      dq_in = dq_ff;
      dd_in = dd_ff;
      dr_in = dr_ff;
      dcnt_in = dcnt_ff;
      resv_in = resv_ff;
      ress_in = ress_ff;
      ov_in = ov_ff && !rsp_chan.ready;
      ovv_in = ovv_ff;
      ovs_in = ovs_ff;
      stk_we = 1'b0;
      stk_wa = lvl_ff[SAW-1:0];
      stk_wd = job_ff.number;
      var_we = 1'b0;
      key_we = 1'b0;
      var_wa = sidx_ff;
      val_wd = top_ff;
      job_pop = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            sidx_in = '0;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            resv_in = 16'd0;
            ress_in = pfx_pkg::ST_OK;
            state_in = S_OUT;
            case (job_ff.cmd)
               pfx_pkg::CMD_PUSH_NUM: begin
                  if (full_stk) ress_in = pfx_pkg::ST_OVER;
                  else begin
                     stk_we = 1'b1;
                     lvl_in = lvl_ff + LW'(1);
                  end
               end
               pfx_pkg::CMD_PUSH_VAR: begin
                  if (full_stk) ress_in = pfx_pkg::ST_OVER;
                  else if (cnt_ff == '0) begin
                     stk_we = 1'b1;
                     stk_wd = 16'd0;
                     lvl_in = lvl_ff + LW'(1);
                  end else state_in = S_SRD;
               end
               pfx_pkg::CMD_OPERATE: begin
                  if (job_ff.op inside {pfx_pkg::OP_NEG, pfx_pkg::OP_NOT, pfx_pkg::OP_ABS,
                                        pfx_pkg::OP_ZERO}) begin
                     if (lvl_ff == '0) ress_in = pfx_pkg::ST_UNDER;
                     else begin
                        stk_we = 1'b1;
                        stk_wa = lvl_m1[SAW-1:0];
                        stk_wd = r_un;
                     end
                  end else if (job_ff.op <= pfx_pkg::OP_ZERO) begin
                     if (lvl_ff < LW'(2)) ress_in = pfx_pkg::ST_UNDER;
                     else if (job_ff.op inside {pfx_pkg::OP_DIV, pfx_pkg::OP_MOD}) begin
                        if (top_ff == 16'd0) ress_in = pfx_pkg::ST_DIVZ;
                        else begin
                           dq_in = ua;
                           dd_in = ub;
                           dr_in = '0;
                           dcnt_in = '0;
                           state_in = S_DIV;
                        end
                     end else begin
                        stk_we = 1'b1;
                        stk_wa = lvl_m2[SAW-1:0];
                        stk_wd = r_bin;
                        lvl_in = lvl_m1;
                     end
                  end
               end
               pfx_pkg::CMD_POP: begin
                  if (lvl_ff == '0) ress_in = pfx_pkg::ST_UNDER;
                  else begin
                     resv_in = top_ff;
                     lvl_in = lvl_m1;
                  end
               end
               pfx_pkg::CMD_ASSIGN: begin
                  if (lvl_ff == '0) ress_in = pfx_pkg::ST_UNDER;
                  else if (cnt_ff == '0) begin
                     var_we = 1'b1;
                     key_we = 1'b1;
                     var_wa = '0;
                     cnt_in = cnt_ff + CW'(1);
                     lvl_in = lvl_m1;
                  end else state_in = S_SRD;
               end
               default: ;
            endcase
         end
         S_SRD: state_in = S_SCMP;
         S_SCMP: begin
            if (hit || last) begin
               state_in = S_OUT;
               if (job_ff.cmd == pfx_pkg::CMD_PUSH_VAR) begin
                  stk_we = 1'b1;
                  stk_wd = hit ? vr_ff : 16'd0;
                  lvl_in = lvl_ff + LW'(1);
               end else if (hit) begin
                  var_we = 1'b1;
                  lvl_in = lvl_m1;
               end else if (cnt_ff >= CW'(VAR_SLOTS)) begin
                  ress_in = pfx_pkg::ST_FULL;
               end else begin
                  var_we = 1'b1;
                  key_we = 1'b1;
                  var_wa = cnt_ff[VIW-1:0];
                  cnt_in = cnt_ff + CW'(1);
                  lvl_in = lvl_m1;
               end
            end else begin
               sidx_in = sidx_ff + VIW'(1);
               state_in = S_SRD;
            end
         end
         S_DIV: begin
            if (dt >= {1'b0, dd_ff}) begin
               dr_in = dt - {1'b0, dd_ff};
               dq_in = {dq_ff[14:0], 1'b1};
            end else begin
               dr_in = dt;
               dq_in = {dq_ff[14:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 4'd1;
            if (dcnt_ff == 4'd15) state_in = S_DIVF;
         end
         S_DIVF: begin
            stk_we = 1'b1;
            stk_wa = lvl_m2[SAW-1:0];
            stk_wd = (job_ff.op == pfx_pkg::OP_DIV) ? qv : rv;
            lvl_in = lvl_m1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!ov_ff || rsp_chan.ready) begin
               ov_in = 1'b1;
               ovv_in = resv_ff;
               ovs_in = ress_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && job_valid) job_ff <= job;
      if (state_ff == S_READ) begin
         top_ff <= stk_mem[lvl_m1[SAW-1:0]];
         nxt_ff <= stk_mem[lvl_m2[SAW-1:0]];
      end
      if (state_ff == S_SRD) begin
         kr_ff <= key_mem[sidx_ff];
         vr_ff <= val_mem[sidx_ff];
      end
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      if (var_we) val_mem[var_wa] <= val_wd;
      if (key_we) key_mem[var_wa] <= job_ff.key;
      sidx_ff <= sidx_in;
      dq_ff <= dq_in;
      dd_ff <= dd_in;
      dr_ff <= dr_in;
      dcnt_ff <= dcnt_in;
      resv_ff <= resv_in;
      ress_ff <= ress_in;
      ovv_ff <= ovv_in;
      ovs_ff <= ovs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lvl_ff <= '0;
         cnt_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lvl_ff <= lvl_in;
         cnt_ff <= cnt_in;
         ov_ff <= ov_in;
      end
   end

   assign rsp_chan.valid  = ov_ff;
   assign rsp_chan.value  = ovv_ff;
   assign rsp_chan.status = ovs_ff;

endmodule

>>> rtl/core/postfix_expression_stack_engine.sv
// top level of the postfix expression stack engine
// Evaluates postfix tokens on 16-bit signed values, one response transaction per request
// transaction. A two-entry job queue in the front end keeps taking requests while the back
// end works and the queue has room. The back end handles one job at a time: a divide or
// modulo runs a 16-step shift-subtract loop, and a variable read or assign scans the table
// of names up to a match or the last entry, with one registered table read and one key
// compare per entry.
module postfix_expression_stack_engine #(
   parameter int STACK_DEPTH = 32,
   parameter int VAR_SLOTS   = 64
) (
   input logic        clock,
   input logic        reset,
   pfx_req_if.sink    req_chan,
   pfx_rsp_if.source  rsp_chan
);

   pfx_pkg::job_type job;
   logic             job_valid;
   logic             job_pop;

   // front: key forming and job queue
   pfx_front u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan),
      .job(job), .job_valid(job_valid), .job_pop(job_pop)
   );

   // back: stack, variable table and arithmetic
   pfx_back #(.STACK_DEPTH(STACK_DEPTH), .VAR_SLOTS(VAR_SLOTS)) u_back (
      .clock(clock), .reset(reset),
      .job(job), .job_valid(job_valid), .job_pop(job_pop),
      .rsp_chan(rsp_chan)
   );

`ifndef SYNTHESIS
   // no response right after reset
   a_rst_quiet: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid after reset");
   // only known status codes
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.status <= pfx_pkg::ST_FULL)
      else $error("bad status code");
   // an error transaction carries zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != pfx_pkg::ST_OK) |-> rsp_chan.value == 16'd0)
      else $error("error response with nonzero value");
`endif

endmodule
